// ===== design/aavr_pkg.sv =====
package aavr_pkg;

  localparam int unsigned CordicStepsDef = 24;
  localparam int unsigned MaxSteps = 32;
  localparam int unsigned CordicW = 34;
  localparam int unsigned ZW = 32;

  localparam logic signed [CordicW-1:0] CordicGainInv = 34'sd652032874;
  localparam logic signed [31:0] Q30One = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic [31:0] turn_angle;
  } req_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic overflow;
  } res_t;

  // Vector and clamped axis carried alongside the rotation chain.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
  } side_t;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0] quad;
  } rot_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int unsigned i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        0: r = 536870912;   1: r = 316933406;  2: r = 167458907;
        3: r = 85004756;    4: r = 42667331;   5: r = 21354465;
        6: r = 10679838;    7: r = 5340245;    8: r = 2670163;
        9: r = 1335087;     10: r = 667544;    11: r = 333772;
        12: r = 166886;     13: r = 83443;     14: r = 41722;
        15: r = 20861;      16: r = 10430;     17: r = 5215;
        18: r = 2608;       19: r = 1304;      20: r = 652;
        21: r = 326;        22: r = 163;       23: r = 81;
        24: r = 41;         25: r = 20;        26: r = 10;
        27: r = 5;          28: r = 3;         29: r = 1;
        30: r = 1;          default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] v);
    begin
      if (v > Q30One) return Q30One;
      else if (v < -Q30One) return -Q30One;
      else return v;
    end
  endfunction

endpackage

// ===== design/aavr_cell.sv =====
module aavr_cell #(
  parameter int unsigned Step = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  aavr_pkg::rot_t rot_i,
  input  aavr_pkg::side_t side_i,
  output logic           vld_o,
  output aavr_pkg::rot_t rot_o,
  output aavr_pkg::side_t side_o
);
  import aavr_pkg::*;

  rot_t rot_d, rot_q;
  side_t side_q;
  logic vld_q;

  always_comb begin
    rot_d = rot_i;
    if (!rot_i.z[ZW-1]) begin
      rot_d.x = rot_i.x - (rot_i.y >>> Step);
      rot_d.y = rot_i.y + (rot_i.x >>> Step);
      rot_d.z = rot_i.z - atan_turn(Step);
    end else begin
      rot_d.x = rot_i.x + (rot_i.y >>> Step);
      rot_d.y = rot_i.y - (rot_i.x >>> Step);
      rot_d.z = rot_i.z + atan_turn(Step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q  <= rot_d;
    side_q <= side_i;
  end

  assign vld_o  = vld_q;
  assign rot_o  = rot_q;
  assign side_o = side_q;
endmodule

// ===== design/aavr_matrix.sv =====
module aavr_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  aavr_pkg::rot_t  rot_i,
  input  aavr_pkg::side_t side_i,
  output logic            vld_o,
  output aavr_pkg::res_t  res_o
);
  import aavr_pkg::*;

  // Stage 1: quadrant fix, c/s, t, axis products.
  logic signed [CordicW-1:0] c_d, s_d;
  logic signed [CordicW-1:0] c1_q, s1_q, t1_q;
  logic signed [63:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  side_t sd1_q, sd2_q, sd3_q;
  logic [3:0] vld_q;

  always_comb begin
    case (rot_i.quad)
      2'd0: begin c_d = rot_i.x;  s_d = rot_i.y;  end
      2'd1: begin c_d = -rot_i.y; s_d = rot_i.x;  end
      2'd2: begin c_d = -rot_i.x; s_d = -rot_i.y; end
      default: begin c_d = rot_i.y; s_d = -rot_i.x; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= c_d;
    s1_q  <= s_d;
    t1_q  <= CordicW'(Q30One) - c_d;
    pxx_q <= side_i.ux * side_i.ux;
    pyy_q <= side_i.uy * side_i.uy;
    pzz_q <= side_i.uz * side_i.uz;
    pxy_q <= side_i.ux * side_i.uy;
    pxz_q <= side_i.ux * side_i.uz;
    pyz_q <= side_i.uy * side_i.uz;
    sd1_q <= side_i;
  end

  // Stage 2: round axis products, multiply by t; axis times s.
  function automatic logic signed [33:0] r30(input logic signed [67:0] v);
    logic signed [67:0] w;
    begin
      w = (v + 68'sd536870912) >>> 30;
      return w[33:0];
    end
  endfunction

  logic signed [67:0] mxx_q, myy_q, mzz_q, mxy_q, mxz_q, myz_q;
  logic signed [67:0] mxs_q, mys_q, mzs_q;
  logic signed [CordicW-1:0] c2_q;

  always_ff @(posedge clk_i) begin
    mxx_q <= r30(68'(pxx_q)) * t1_q;
    myy_q <= r30(68'(pyy_q)) * t1_q;
    mzz_q <= r30(68'(pzz_q)) * t1_q;
    mxy_q <= r30(68'(pxy_q)) * t1_q;
    mxz_q <= r30(68'(pxz_q)) * t1_q;
    myz_q <= r30(68'(pyz_q)) * t1_q;
    mxs_q <= sd1_q.ux * s1_q;
    mys_q <= sd1_q.uy * s1_q;
    mzs_q <= sd1_q.uz * s1_q;
    c2_q  <= c1_q;
    sd2_q <= sd1_q;
  end

  // Stage 3: nine matrix terms.
  logic signed [35:0] r_q [9];
  logic signed [35:0] xx, yy, zz, xy, xz, yz, xs, ys, zs, cc;

  always_comb begin
    xx = 36'(r30(mxx_q)); yy = 36'(r30(myy_q)); zz = 36'(r30(mzz_q));
    xy = 36'(r30(mxy_q)); xz = 36'(r30(mxz_q)); yz = 36'(r30(myz_q));
    xs = 36'(r30(mxs_q)); ys = 36'(r30(mys_q)); zs = 36'(r30(mzs_q));
    cc = 36'(c2_q);
  end

  always_ff @(posedge clk_i) begin
    r_q[0] <= xx + cc; r_q[1] <= xy - zs; r_q[2] <= xz + ys;
    r_q[3] <= xy + zs; r_q[4] <= yy + cc; r_q[5] <= yz - xs;
    r_q[6] <= xz - ys; r_q[7] <= yz + xs; r_q[8] <= zz + cc;
    sd3_q  <= sd2_q;
  end

  // Stage 4: products by vector, each floor shifted by 2.
  logic signed [67:0] pv_q [9];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pv_q[3*k]   <= (r_q[3*k]   * sd3_q.vx) >>> 2;
      pv_q[3*k+1] <= (r_q[3*k+1] * sd3_q.vy) >>> 2;
      pv_q[3*k+2] <= (r_q[3*k+2] * sd3_q.vz) >>> 2;
    end
  end

  // Stage 5: sum, round, saturate.
  logic signed [31:0] o_d [3];
  logic [2:0] ov_d;
  res_t res_q;
  always_comb begin
    logic signed [69:0] acc;
    for (int k = 0; k < 3; k++) begin
      acc = 70'(pv_q[3*k]) + 70'(pv_q[3*k+1]) + 70'(pv_q[3*k+2]);
      acc = (acc + 70'sd134217728) >>> 28;
      ov_d[k] = 1'b0;
      if (acc > 70'sd2147483647) begin
        o_d[k] = 32'sh7FFFFFFF; ov_d[k] = 1'b1;
      end else if (acc < -70'sd2147483648) begin
        o_d[k] = 32'sh80000000; ov_d[k] = 1'b1;
      end else begin
        o_d[k] = acc[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.rot_x    <= o_d[0];
    res_q.rot_y    <= o_d[1];
    res_q.rot_z    <= o_d[2];
    res_q.overflow <= |ov_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  logic vld5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
    end else begin
      vld5_q <= vld_q[3];
    end
  end

  assign vld_o = vld5_q;
  assign res_o = res_q;
endmodule

// ===== design/axis_angle_vector_rotation.sv =====
// Axis-angle vector rotation (Rodrigues form), fixed point.
// Request channel: drive req_i and pulse start; the request is taken at
// any edge with start high and busy low. busy is always low here, so
// one request can enter every cycle.
// Result channel: done_o is high for exactly one cycle with res_o valid;
// the receiver cannot stall, so results are never held back.
// Pipeline: the input register loads at the accepting edge, then one
// CORDIC cell per step, then five matrix stages, the last of which
// registers done_o and res_o.
// Throughput: one rotation per cycle, set by the fully pipelined cell row.
// Reset clears all valid bits; payload registers keep whatever they hold.
// Vector Q16.16, axis Q2.30 (clamped to +-1.0), angle in turns of 2^32.
module axis_angle_vector_rotation #(
  parameter int unsigned CORDIC_STEPS = aavr_pkg::CordicStepsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  aavr_pkg::req_t req_i,
  output logic           done_o,
  output aavr_pkg::res_t res_o
);
  import aavr_pkg::*;

  // Input register: angle reduction to quadrant and residue.
  logic       vld_q;
  rot_t       rot_q;
  side_t      side_q;
  logic [31:0] b;

  assign busy = 1'b0;
  assign b = req_i.turn_angle + 32'h2000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q.x    <= CordicGainInv;
    rot_q.y    <= '0;
    rot_q.z    <= $signed({2'b00, b[29:0]}) - 32'sh2000_0000;
    rot_q.quad <= b[31:30];
    side_q.vx  <= req_i.vec_x;
    side_q.vy  <= req_i.vec_y;
    side_q.vz  <= req_i.vec_z;
    side_q.ux  <= clamp_axis(req_i.axis_x);
    side_q.uy  <= clamp_axis(req_i.axis_y);
    side_q.uz  <= clamp_axis(req_i.axis_z);
  end

  // Row of CORDIC cells, one micro-rotation each.
  logic  vld_c  [CORDIC_STEPS+1];
  rot_t  rot_c  [CORDIC_STEPS+1];
  side_t side_c [CORDIC_STEPS+1];

  assign vld_c[0]  = vld_q;
  assign rot_c[0]  = rot_q;
  assign side_c[0] = side_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    aavr_cell #(.Step(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (vld_c[g]),
      .rot_i (rot_c[g]),
      .side_i(side_c[g]),
      .vld_o (vld_c[g+1]),
      .rot_o (rot_c[g+1]),
      .side_o(side_c[g+1])
    );
  end

  // Rotation matrix build and matrix-vector product.
  aavr_matrix u_matrix (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (vld_c[CORDIC_STEPS]),
    .rot_i (rot_c[CORDIC_STEPS]),
    .side_i(side_c[CORDIC_STEPS]),
    .vld_o (done_o),
    .res_o (res_o)
  );

`ifndef SYNTH
  // A request always yields a result after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> ##(CORDIC_STEPS+5) done_o) else $error("result missing");
  // No result without a request having left the cell row into the matrix stages.
  a_no_spur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_c[CORDIC_STEPS], 5)) else $error("spurious");
  // Overflow implies a saturated component.
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.overflow) |->
      (res_o.rot_x == 32'sh7FFFFFFF || res_o.rot_x == 32'sh80000000 ||
       res_o.rot_y == 32'sh7FFFFFFF || res_o.rot_y == 32'sh80000000 ||
       res_o.rot_z == 32'sh7FFFFFFF || res_o.rot_z == 32'sh80000000))
    else $error("overflow without saturation");
`endif
endmodule
